// ===== rtl/dpt_pkg.sv =====
package dpt_pkg;

    // Item kinds carried in the input tuser.
    typedef enum logic [1:0] {
        FUNC_EVENT  = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_START  = 2'd2,
        FUNC_UNUSED = 2'd3
    } t_func;

    // Event codes.
    localparam logic [3:0] EV_BUTTON    = 4'd0;
    localparam logic [3:0] EV_INTERACT  = 4'd1;
    localparam logic [3:0] EV_TAP       = 4'd2;
    localparam logic [3:0] EV_SWIPE_UP  = 4'd3;
    localparam logic [3:0] EV_SWIPE_DN  = 4'd4;
    localparam logic [3:0] EV_SWIPE_LT  = 4'd5;
    localparam logic [3:0] EV_SWIPE_RT  = 4'd6;
    localparam logic [3:0] EV_TIMEOUT   = 4'd7;
    localparam logic [3:0] EV_ALARM     = 4'd8;
    localparam logic [3:0] EV_CALL      = 4'd9;
    localparam logic [3:0] EV_SOS       = 4'd10;

    // Register indexes on the configuration port.
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_MODE    = 1'b1;

    // Time base and timing constants.
    localparam int TIME_BITS_DEF     = 32;
    localparam int NOW_W             = 32;
    localparam int TIMEOUT_MS_W      = 26;
    localparam logic [15:0] ULTRA_DEFAULT_SEC = 16'd10;
    localparam logic [9:0]  MS_PER_SEC        = 10'd1000;
    localparam int GRACE_MS          = 1500;
    localparam logic [1:0]  ULTRA_MODE        = 2'd2;

    // One accepted command.
    typedef struct packed {
        t_func              func;
        logic [3:0]         event_code;
        logic [NOW_W-1:0]   now_ms;
        logic               start_on;
    } t_cmd;

    // One result.
    typedef struct packed {
        logic screen_is_on;
        logic deep_sleep_cmd;
        logic screen_off_cmd;
        logic screen_on_cmd;
    } t_result;

    // Configuration values seen by the core.
    typedef struct packed {
        logic [15:0] timeout_seconds;
        logic [1:0]  power_mode;
    } t_cfg;

endpackage

// ===== rtl/dpt_cfg.sv =====
module dpt_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output dpt_pkg::t_cfg     o_cfg
);

    logic [15:0] r_timeout;
    logic [1:0]  r_mode;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= '0;
            r_mode    <= '0;
        end else if (w_wr) begin
            if (paddr[2] == dpt_pkg::REG_TIMEOUT) begin
                r_timeout <= pwdata[15:0];
            end else begin
                r_mode <= pwdata[1:0];
            end
        end
    end

    // Read back the addressed register.
    always_comb begin
        if (paddr[2] == dpt_pkg::REG_TIMEOUT) begin
            prdata = {16'd0, r_timeout};
        end else begin
            prdata = {30'd0, r_mode};
        end
    end

    assign o_cfg.timeout_seconds = r_timeout;
    assign o_cfg.power_mode      = r_mode;

endmodule

// ===== rtl/dpt_core.sv =====
module dpt_core #(
    parameter int TIME_BITS = dpt_pkg::TIME_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  dpt_pkg::t_cmd     i_cmd,
    input  dpt_pkg::t_cfg     i_cfg,
    output dpt_pkg::t_result  o_result
);

    localparam int CMP_W = (TIME_BITS > dpt_pkg::TIMEOUT_MS_W) ?
                           TIME_BITS : dpt_pkg::TIMEOUT_MS_W;

    logic                  r_on, n_on;
    logic [TIME_BITS-1:0]  r_last, n_last;
    logic [TIME_BITS-1:0]  r_off, n_off;
    logic                  r_off_valid, n_off_valid;

    logic [63:0]                     w_now_ext;
    logic [TIME_BITS-1:0]            w_now;
    logic                            w_ultra;
    logic [15:0]                     w_eff_sec;
    logic [dpt_pkg::TIMEOUT_MS_W-1:0] w_timeout_ms;
    logic [TIME_BITS-1:0]            w_since_touch;
    logic [TIME_BITS-1:0]            w_since_off;
    logic                            w_expired;
    logic                            w_grace_done;
    logic                            w_on_cmd, w_off_cmd, w_ds_cmd;

    // Current time reduced to the time base.
    assign w_now_ext = {32'd0, i_cmd.now_ms};
    assign w_now     = w_now_ext[TIME_BITS-1:0];

    // Effective timeout; ultra mode turns a zero timeout into the default.
    assign w_ultra   = i_cfg.power_mode >= dpt_pkg::ULTRA_MODE;
    assign w_eff_sec = (w_ultra && i_cfg.timeout_seconds == 16'd0) ?
                       dpt_pkg::ULTRA_DEFAULT_SEC : i_cfg.timeout_seconds;
    assign w_timeout_ms = dpt_pkg::TIMEOUT_MS_W'(w_eff_sec) *
                          dpt_pkg::TIMEOUT_MS_W'(dpt_pkg::MS_PER_SEC);

    // Wrapping elapsed times and their threshold compares.
    assign w_since_touch = w_now - r_last;
    assign w_since_off   = w_now - r_off;
    assign w_expired     = CMP_W'(w_since_touch) >= CMP_W'(w_timeout_ms);
    assign w_grace_done  = w_since_off >= TIME_BITS'(dpt_pkg::GRACE_MS);

    // Next state for one command.
    always_comb begin
        n_on        = r_on;
        n_last      = r_last;
        n_off       = r_off;
        n_off_valid = r_off_valid;
        w_on_cmd    = 1'b0;
        w_off_cmd   = 1'b0;
        w_ds_cmd    = 1'b0;
        unique case (i_cmd.func)
            dpt_pkg::FUNC_START: begin
                n_on        = i_cmd.start_on;
                n_last      = w_now;
                n_off_valid = !i_cmd.start_on;
                n_off       = i_cmd.start_on ? '0 : w_now;
            end
            dpt_pkg::FUNC_EVENT: begin
                unique case (i_cmd.event_code)
                    dpt_pkg::EV_BUTTON: begin
                        if (r_on) begin
                            n_on        = 1'b0;
                            n_off       = w_now;
                            n_off_valid = 1'b1;
                            w_off_cmd   = 1'b1;
                        end else begin
                            n_last      = w_now;
                            n_on        = 1'b1;
                            n_off_valid = 1'b0;
                            n_off       = '0;
                            w_on_cmd    = 1'b1;
                        end
                    end
                    dpt_pkg::EV_INTERACT, dpt_pkg::EV_ALARM,
                    dpt_pkg::EV_CALL, dpt_pkg::EV_SOS: begin
                        // Wake; while already on only the touch time moves.
                        n_last = w_now;
                        if (!r_on) begin
                            n_on        = 1'b1;
                            n_off_valid = 1'b0;
                            n_off       = '0;
                            w_on_cmd    = 1'b1;
                        end
                    end
                    dpt_pkg::EV_TAP, dpt_pkg::EV_SWIPE_UP, dpt_pkg::EV_SWIPE_DN,
                    dpt_pkg::EV_SWIPE_LT, dpt_pkg::EV_SWIPE_RT: begin
                        if (r_on) begin
                            n_last = w_now;
                        end
                    end
                    dpt_pkg::EV_TIMEOUT: begin
                        if (r_on) begin
                            n_on        = 1'b0;
                            n_off       = w_now;
                            n_off_valid = 1'b1;
                            w_off_cmd   = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            dpt_pkg::FUNC_TICK: begin
                if (r_on && w_eff_sec != 16'd0) begin
                    if (w_expired) begin
                        n_on        = 1'b0;
                        n_off       = w_now;
                        n_off_valid = 1'b1;
                        w_off_cmd   = 1'b1;
                    end
                end else if (!r_on && w_ultra && r_off_valid) begin
                    // Grace period over: request deep sleep and re-arm.
                    if (w_grace_done) begin
                        w_ds_cmd = 1'b1;
                        n_off    = w_now;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // State advances once per command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on        <= 1'b0;
            r_last      <= '0;
            r_off       <= '0;
            r_off_valid <= 1'b0;
        end else if (i_en) begin
            r_on        <= n_on;
            r_last      <= n_last;
            r_off       <= n_off;
            r_off_valid <= n_off_valid;
        end
    end

    assign o_result.screen_on_cmd  = w_on_cmd;
    assign o_result.screen_off_cmd = w_off_cmd;
    assign o_result.deep_sleep_cmd = w_ds_cmd;
    assign o_result.screen_is_on   = n_on;

endmodule

// ===== rtl/display_power_timeout_controller_unit.sv =====
// Flow: an accepted transaction is held in the input register, and its result is registered
// in the result register, from which the result transaction completes.
// Throughput: one transaction per cycle; the single-pass logic between the input
// register and the result register sets this, and stalls only follow m_axis_tready.
// Reset: synchronous, active low; screen off, no off time recorded, state and configuration registers zero.
module display_power_timeout_controller_unit #(
    parameter int TIME_BITS = dpt_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Command stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // event_code[3:0], now_ms[35:4], start_on[36], zero
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // screen_on_cmd, screen_off_cmd, deep_sleep_cmd,
                                       // screen_is_on, zero
);

    dpt_pkg::t_cfg    w_cfg;
    dpt_pkg::t_cmd    r_cmd;
    dpt_pkg::t_result w_result;
    dpt_pkg::t_result r_result;
    logic             r_cmd_valid;
    logic             r_out_valid;
    logic             w_advance;
    logic             w_accept;

    dpt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The held command moves on when the result register is free or drains.
    assign w_advance     = r_cmd_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_cmd_valid || w_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_cmd_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.func       <= dpt_pkg::t_func'(s_axis_tuser);
            r_cmd.event_code <= s_axis_tdata[3:0];
            r_cmd.now_ms     <= s_axis_tdata[35:4];
            r_cmd.start_on   <= s_axis_tdata[36];
        end
    end

    dpt_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_advance),
        .i_cmd    (r_cmd),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_result};

endmodule

// ===== bench/testbench.sv =====
module testbench;

    // A run of cycles with no transaction on any port this long means a hang.
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 244;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // event_code, now_ms, start_on, zero
    logic [1:0]  s_axis_tuser = '0;  // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;       // screen_on_cmd, screen_off_cmd, deep_sleep_cmd,
                                     // screen_is_on, zero

    // Predicted screen state and the configuration it runs under.
    logic        scr_on = 1'b0;
    logic [31:0] touch_ms = '0;
    logic [31:0] off_ms = '0;
    logic        off_valid = 1'b0;
    logic [15:0] cfg_timeout_s = '0;
    logic [1:0]  cfg_mode = '0;

    // Expected screen results, oldest first.
    dpt_pkg::t_result screen_results_q[$];

    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          mismatch_count = 0;
    int          results_checked = 0;
    int          quiet_cycles = 0;
    logic [31:0] clock_ms;

    display_power_timeout_controller_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advance the predicted state by one command and return its result.
    function automatic dpt_pkg::t_result predict_screen(dpt_pkg::t_cmd c);
        dpt_pkg::t_result r;
        logic        wake_req;
        logic        sleep_req;
        logic        ultra;
        logic [15:0] eff_s;
        logic [31:0] span_ms;
        r = '0;
        wake_req = 1'b0;
        sleep_req = 1'b0;
        ultra = (cfg_mode >= dpt_pkg::ULTRA_MODE);
        eff_s = cfg_timeout_s;
        if (ultra && eff_s == 16'd0) begin
            eff_s = dpt_pkg::ULTRA_DEFAULT_SEC;
        end
        case (c.func)
            dpt_pkg::FUNC_START: begin
                scr_on = c.start_on;
                touch_ms = c.now_ms;
                off_valid = !c.start_on;
                off_ms = c.start_on ? 32'd0 : c.now_ms;
            end
            dpt_pkg::FUNC_EVENT: begin
                case (c.event_code)
                    dpt_pkg::EV_BUTTON: begin
                        if (scr_on) sleep_req = 1'b1;
                        else wake_req = 1'b1;
                    end
                    dpt_pkg::EV_INTERACT, dpt_pkg::EV_ALARM, dpt_pkg::EV_CALL,
                    dpt_pkg::EV_SOS: begin
                        wake_req = 1'b1;
                    end
                    dpt_pkg::EV_TAP, dpt_pkg::EV_SWIPE_UP, dpt_pkg::EV_SWIPE_DN,
                    dpt_pkg::EV_SWIPE_LT, dpt_pkg::EV_SWIPE_RT: begin
                        if (scr_on) touch_ms = c.now_ms;
                    end
                    dpt_pkg::EV_TIMEOUT: begin
                        sleep_req = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            dpt_pkg::FUNC_TICK: begin
                if (scr_on && eff_s != 16'd0) begin
                    span_ms = c.now_ms - touch_ms;
                    if (span_ms >= 32'(eff_s) * 32'(dpt_pkg::MS_PER_SEC)) sleep_req = 1'b1;
                end else if (!scr_on && ultra && off_valid) begin
                    // Grace period elapsed: request deep sleep and re-arm.
                    span_ms = c.now_ms - off_ms;
                    if (span_ms >= 32'(dpt_pkg::GRACE_MS)) begin
                        r.deep_sleep_cmd = 1'b1;
                        off_ms = c.now_ms;
                    end
                end
            end
            default: begin
            end
        endcase
        if (wake_req) begin
            touch_ms = c.now_ms;
            if (!scr_on) begin
                scr_on = 1'b1;
                off_valid = 1'b0;
                off_ms = '0;
                r.screen_on_cmd = 1'b1;
            end
        end
        if (sleep_req && scr_on) begin
            scr_on = 1'b0;
            off_ms = c.now_ms;
            off_valid = 1'b1;
            r.screen_off_cmd = 1'b1;
        end
        r.screen_is_on = scr_on;
        return r;
    endfunction

    // Send one command, with random idle cycles ahead of it.
    task automatic send_cmd(dpt_pkg::t_func f, logic [3:0] code, logic [31:0] now,
                            logic on);
        dpt_pkg::t_cmd c;
        c.func = f;
        c.event_code = code;
        c.now_ms = now;
        c.start_on = on;
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, c.start_on, c.now_ms, c.event_code};
        s_axis_tuser <= c.func;
        do @(posedge i_clk); while (!s_axis_tready);
        screen_results_q.push_back(predict_screen(c));
    endtask

    // Wait until every expected result has arrived and the pipeline is empty.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (screen_results_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register write: setup phase, access phase, then the bus returns to idle.
    task automatic write_reg(logic index, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == dpt_pkg::REG_TIMEOUT) cfg_timeout_s = value[15:0];
        else cfg_mode = value[1:0];
        @(posedge i_clk);
    endtask

    // Reconfigure the block once it is idle.
    task automatic set_power_config(logic [15:0] timeout_s, logic [1:0] mode);
        drain_results();
        write_reg(dpt_pkg::REG_TIMEOUT, {16'd0, timeout_s});
        write_reg(dpt_pkg::REG_MODE, {30'd0, mode});
    endtask

    // Commands straight out of reset, before any start, with reset configuration.
    task automatic test_from_reset();
        send_cmd(dpt_pkg::FUNC_TICK, dpt_pkg::EV_BUTTON, 32'd0, 1'b0);
        send_cmd(dpt_pkg::FUNC_UNUSED, 4'hF, 32'hFFFF_FFFF, 1'b1);
        send_cmd(dpt_pkg::FUNC_EVENT, dpt_pkg::EV_TAP, 32'd3, 1'b0);
        send_cmd(dpt_pkg::FUNC_EVENT, dpt_pkg::EV_SOS, 32'd5, 1'b0);
        send_cmd(dpt_pkg::FUNC_TICK, dpt_pkg::EV_BUTTON, 32'hFFFF_FFFF, 1'b0);
        send_cmd(dpt_pkg::FUNC_EVENT, dpt_pkg::EV_SWIPE_RT, 32'd40, 1'b1);
        send_cmd(dpt_pkg::FUNC_EVENT, 4'd15, 32'd41, 1'b0);
        send_cmd(dpt_pkg::FUNC_EVENT, dpt_pkg::EV_TIMEOUT, 32'd50, 1'b0);
        send_cmd(dpt_pkg::FUNC_EVENT, dpt_pkg::EV_TIMEOUT, 32'd60, 1'b0);
    endtask

    // One-second timeout across the wrap of the time counter, wake and button.
    task automatic test_timeout_wrap();
        set_power_config(16'd1, 2'd0);
        send_cmd(dpt_pkg::FUNC_START, dpt_pkg::EV_BUTTON, 32'hFFFF_FE00, 1'b1);
        send_cmd(dpt_pkg::FUNC_TICK, dpt_pkg::EV_BUTTON, 32'hFFFF_FE00 + 32'd999, 1'b0);
        send_cmd(dpt_pkg::FUNC_TICK, dpt_pkg::EV_BUTTON, 32'hFFFF_FE00 + 32'd1000, 1'b0);
        send_cmd(dpt_pkg::FUNC_EVENT, dpt_pkg::EV_INTERACT, 32'd600, 1'b0);
        send_cmd(dpt_pkg::FUNC_EVENT, dpt_pkg::EV_INTERACT, 32'd700, 1'b0);
        send_cmd(dpt_pkg::FUNC_EVENT, dpt_pkg::EV_BUTTON, 32'd800, 1'b0);
    endtask

    // Ultra mode: default timeout and repeated deep-sleep requests.
    task automatic test_ultra_grace();
        set_power_config(16'd0, dpt_pkg::ULTRA_MODE);
        send_cmd(dpt_pkg::FUNC_START, dpt_pkg::EV_BUTTON, 32'd1000, 1'b0);
        send_cmd(dpt_pkg::FUNC_TICK, dpt_pkg::EV_BUTTON, 32'd2499, 1'b0);
        send_cmd(dpt_pkg::FUNC_TICK, dpt_pkg::EV_BUTTON, 32'd2500, 1'b0);
        send_cmd(dpt_pkg::FUNC_TICK, dpt_pkg::EV_BUTTON, 32'd4000, 1'b0);
        send_cmd(dpt_pkg::FUNC_EVENT, dpt_pkg::EV_ALARM, 32'd5000, 1'b0);
        send_cmd(dpt_pkg::FUNC_TICK, dpt_pkg::EV_BUTTON, 32'd14999, 1'b0);
        send_cmd(dpt_pkg::FUNC_TICK, dpt_pkg::EV_BUTTON, 32'd15000, 1'b0);
    endtask

    // Largest timeout with the top power mode.
    task automatic test_extreme_timeout();
        set_power_config(16'hFFFF, 2'd3);
        send_cmd(dpt_pkg::FUNC_EVENT, dpt_pkg::EV_CALL, 32'd0, 1'b0);
        send_cmd(dpt_pkg::FUNC_TICK, dpt_pkg::EV_BUTTON, 32'd65534999, 1'b0);
        send_cmd(dpt_pkg::FUNC_TICK, dpt_pkg::EV_BUTTON, 32'd65535000, 1'b0);
        send_cmd(dpt_pkg::FUNC_TICK, dpt_pkg::EV_BUTTON, 32'd65536500, 1'b1);
    endtask

    // Random traffic on a running clock, through several settings and idling phases.
    task automatic test_random_traffic();
        logic [15:0] timeouts[PHASE_COUNT] = '{16'd2, 16'd0, 16'd1, 16'hFFFF,
                                               16'd5, 16'd0, 16'd3, 16'd7};
        logic [1:0]  modes[PHASE_COUNT] = '{2'd0, 2'd2, 2'd1, 2'd3,
                                            2'd2, 2'd3, 2'd0, 2'd2};
        int          pick;
        dpt_pkg::t_func f;
        logic [3:0]  code;
        logic [31:0] now;
        clock_ms = $urandom;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_power_config(timeouts[p], modes[p]);
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 86; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 86; end
                default: begin src_idle_pct = 9; sink_stall_pct = 9; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Time mostly moves forward in small steps; now and then a jump or noise.
                pick = $urandom_range(99);
                if (pick < 3) begin
                    now = $urandom;
                end else begin
                    if (pick < 10) clock_ms += $urandom_range(70000);
                    else clock_ms += $urandom_range(1800);
                    now = clock_ms;
                end
                pick = $urandom_range(99);
                if (pick < 6) f = dpt_pkg::FUNC_START;
                else if (pick < 10) f = dpt_pkg::FUNC_UNUSED;
                else if (pick < 55) f = dpt_pkg::FUNC_TICK;
                else f = dpt_pkg::FUNC_EVENT;
                if ($urandom_range(99) < 85) code = 4'($urandom_range(10));
                else code = 4'($urandom_range(15));
                send_cmd(f, code, now, 1'($urandom_range(1)));
            end
        end
        src_idle_pct = 0;
        sink_stall_pct = 0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_from_reset();
        test_timeout_wrap();
        test_ultra_grace();
        test_extreme_timeout();
        test_random_traffic();
        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("display_power_timeout_controller_unit regression: pass");
        end else begin
            $display("display_power_timeout_controller_unit regression: fail");
        end
        $finish;
    end

    // Result side backpressure.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Compare every result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        dpt_pkg::t_result got;
        dpt_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = dpt_pkg::t_result'(m_axis_tdata[3:0]);
            if (screen_results_q.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected result on=%b off=%b sleep=%b is_on=%b",
                             got.screen_on_cmd, got.screen_off_cmd,
                             got.deep_sleep_cmd, got.screen_is_on);
                end
                mismatch_count++;
            end else begin
                want = screen_results_q.pop_front();
                if (got.screen_on_cmd !== want.screen_on_cmd ||
                    got.screen_off_cmd !== want.screen_off_cmd ||
                    got.deep_sleep_cmd !== want.deep_sleep_cmd ||
                    got.screen_is_on !== want.screen_is_on) begin
                    if (mismatch_count < 10) begin
                        $display("result %0d: expected on=%b off=%b sleep=%b is_on=%b, %s",
                                 results_checked, want.screen_on_cmd, want.screen_off_cmd,
                                 want.deep_sleep_cmd, want.screen_is_on,
                                 $sformatf("got on=%b off=%b sleep=%b is_on=%b",
                                           got.screen_on_cmd, got.screen_off_cmd,
                                           got.deep_sleep_cmd, got.screen_is_on));
                    end
                    mismatch_count++;
                end
            end
            results_checked++;
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("display_power_timeout_controller_unit regression: fail");
            $finish;
        end
    end

endmodule

// ===== files.f =====
rtl/dpt_pkg.sv
rtl/dpt_cfg.sv
rtl/dpt_core.sv
rtl/display_power_timeout_controller_unit.sv
bench/testbench.sv
